// ===== src/rtue_pkg.sv =====
// Shared types and codes for the route table update engine.
package rtue_pkg;

   localparam int RTUE_TABLE_ENTRIES = 32;
   localparam int RTUE_ADDR_BITS     = 48;
   localparam int ADDR_W             = 48;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DISCARD  = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   localparam logic [1:0] KIND_ADDED   = 2'd0;
   localparam logic [1:0] KIND_CHANGED = 2'd1;
   localparam logic [1:0] KIND_REMOVED = 2'd2;

   typedef struct packed {
      logic [1:0]        command;
      logic [ADDR_W-1:0] dest_addr;
      logic [ADDR_W-1:0] next_hop;
      logic [7:0]        hop_count;
      logic [7:0]        route_flags;
   } rtue_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              update_valid;
      logic [1:0]        update_kind;
      logic [ADDR_W-1:0] out_target;
      logic [ADDR_W-1:0] out_hop;
      logic [7:0]        out_hops;
      logic [7:0]        out_flags;
   } rtue_rsp_type;

   // search token passed from cell to cell
   typedef struct packed {
      logic              live;
      logic              found;
      logic              free_seen;
      logic [ADDR_W-1:0] hop;
      logic [7:0]        hops;
      logic [7:0]        flags;
   } rtue_tok_type;

   typedef enum logic [1:0] {
      WOP_NONE   = 2'd0,
      WOP_ADD    = 2'd1,
      WOP_UPDATE = 2'd2,
      WOP_DELETE = 2'd3
   } rtue_wop_type;

   // write-back broadcast to all cells
   typedef struct packed {
      rtue_wop_type      op;
      logic [ADDR_W-1:0] hop;
      logic [7:0]        hops;
      logic [7:0]        flags;
   } rtue_wr_type;

endpackage

// ===== src/rtue_cell.sv =====
// One route table entry with its stage of the search chain.
module rtue_cell #(
   parameter int KEY_BITS = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [KEY_BITS-1:0]   key,
   input  rtue_pkg::rtue_tok_type tok_in,
   output rtue_pkg::rtue_tok_type tok_out,
   input  rtue_pkg::rtue_wr_type  wr
);
   import rtue_pkg::*;

   logic                valid_ff, valid_in;
   logic [KEY_BITS-1:0] target_ff, target_in;
   logic [KEY_BITS-1:0] hop_ff, hop_in;
   logic [7:0]          hops_ff, hops_in;
   logic [7:0]          flags_ff, flags_in;
   logic                hit_ff, hit_in;
   logic                free_ff, free_in;
   rtue_tok_type        tok_ff, tok_in_next;

   always_comb begin
      tok_in_next = tok_in;
      hit_in      = hit_ff;
      free_in     = free_ff;
      if (tok_in.live) begin
         hit_in  = valid_ff && (target_ff == key) && !tok_in.found;
         free_in = !valid_ff && !tok_in.free_seen;
         if (hit_in) begin
            tok_in_next.found = 1'b1;
            tok_in_next.hop   = ADDR_W'(hop_ff);
            tok_in_next.hops  = hops_ff;
            tok_in_next.flags = flags_ff;
         end
         if (free_in) begin
            tok_in_next.free_seen = 1'b1;
         end
      end
   end

   // write-back lands only in the cell marked by the last search
   always_comb begin
      valid_in  = valid_ff;
      target_in = target_ff;
      hop_in    = hop_ff;
      hops_in   = hops_ff;
      flags_in  = flags_ff;
      case (wr.op)
         WOP_ADD: begin
            if (free_ff) begin
               valid_in  = 1'b1;
               target_in = key;
               hop_in    = wr.hop[KEY_BITS-1:0];
               hops_in   = wr.hops;
               flags_in  = wr.flags;
            end
         end
         WOP_UPDATE: begin
            if (hit_ff) begin
               hop_in   = wr.hop[KEY_BITS-1:0];
               hops_in  = wr.hops;
               flags_in = wr.flags;
            end
         end
         WOP_DELETE: begin
            if (hit_ff) begin
               valid_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
         free_ff  <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
         free_ff  <= free_in;
         tok_ff   <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      hop_ff    <= hop_in;
      hops_ff   <= hops_in;
      flags_ff  <= flags_in;
   end

   assign tok_out = tok_ff;

endmodule

// ===== src/route_table_update_engine.sv =====
// Top level of the route table update engine: request register, cell chain, decision.
//
//  channel   ports                              handshake
//  request   start, busy, req_data              taken when start && !busy
//  result    rsp_strobe, rsp_data               one-cycle strobe, never stalled
//  config    csr_wr_en, csr_wr_data             written when csr_wr_en
//
// A command passes from acceptance through the launch register and then the
// token register of each cell while the search token crosses the chain. It is
// decided and written back as the token leaves the chain. The result strobes
// in the first cycle with busy low. Reset clears every valid bit at once and
// sets the reachable mask to 1. The receiver cannot stall.
module route_table_update_engine #(
   parameter int TABLE_ENTRIES = rtue_pkg::RTUE_TABLE_ENTRIES,
   parameter int ADDR_BITS     = rtue_pkg::RTUE_ADDR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rtue_pkg::rtue_req_type req_data,
   output logic                  rsp_strobe,
   output rtue_pkg::rtue_rsp_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data
);
   import rtue_pkg::*;

   localparam int KEY_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'({KEY_BITS{1'b1}});

   logic         busy_ff, busy_in;
   logic         launch_ff, launch_in;
   logic         rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]   mask_ff, mask_in;
   rtue_req_type req_ff, req_in;
   rtue_rsp_type rsp_ff, rsp_in;
   rtue_wr_type  wr;
   rtue_tok_type tok [TABLE_ENTRIES+1];
   rtue_tok_type tok_head;
   rtue_tok_type tail;
   logic         accept;
   logic         new_reach, old_reach;

   assign accept = start && !busy_ff;
   assign tail   = tok[TABLE_ENTRIES];

   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in           = req_data;
         req_in.dest_addr = req_data.dest_addr & ADDR_MASK;
         req_in.next_hop  = req_data.next_hop & ADDR_MASK;
      end
   end

   assign mask_in   = csr_wr_en ? csr_wr_data : mask_ff;
   assign launch_in = accept;
   assign busy_in   = accept ? 1'b1 : (tail.live ? 1'b0 : busy_ff);

   always_comb begin
      tok_head      = '0;
      tok_head.live = launch_ff;
   end

   assign tok[0] = tok_head;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      rtue_cell #(
         .KEY_BITS(KEY_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .key    (req_ff.dest_addr[KEY_BITS-1:0]),
         .tok_in (tok[i]),
         .tok_out(tok[i+1]),
         .wr     (wr)
      );
   end

   assign new_reach = (req_ff.route_flags & mask_ff) != 8'd0;
   assign old_reach = (tail.flags & mask_ff) != 8'd0;

   always_comb begin
      wr.op         = WOP_NONE;
      wr.hop        = req_ff.next_hop;
      wr.hops       = req_ff.hop_count;
      wr.flags      = req_ff.route_flags;
      rsp_in        = '0;
      rsp_in.status = ST_DISCARD;
      rsp_in.update_kind = KIND_ADDED;
      rsp_in.out_target  = req_ff.dest_addr;
      rsp_strobe_in = tail.live;
      case (req_ff.command)
         CMD_ADD: begin
            if (!tail.found) begin
               rsp_in.out_hop   = req_ff.next_hop;
               rsp_in.out_hops  = req_ff.hop_count;
               rsp_in.out_flags = req_ff.route_flags;
               if (tail.free_seen) begin
                  rsp_in.status       = ST_OK;
                  rsp_in.update_valid = 1'b1;
                  if (tail.live) begin
                     wr.op = WOP_ADD;
                  end
               end else begin
                  rsp_in.status = ST_FULL;
               end
            end else if (new_reach && (!old_reach || (tail.hops > req_ff.hop_count))) begin
               rsp_in.status       = ST_OK;
               rsp_in.update_valid = 1'b1;
               rsp_in.update_kind  = KIND_CHANGED;
               rsp_in.out_hop      = req_ff.next_hop;
               rsp_in.out_hops     = req_ff.hop_count;
               rsp_in.out_flags    = req_ff.route_flags;
               if (tail.live) begin
                  wr.op = WOP_UPDATE;
               end
            end else begin
               rsp_in.out_hop   = tail.hop;
               rsp_in.out_hops  = tail.hops;
               rsp_in.out_flags = tail.flags;
            end
         end
         CMD_REMOVE: begin
            if (tail.found) begin
               rsp_in.status       = ST_OK;
               rsp_in.update_valid = 1'b1;
               rsp_in.update_kind  = KIND_REMOVED;
               rsp_in.out_hop      = tail.hop;
               rsp_in.out_hops     = tail.hops;
               rsp_in.out_flags    = tail.flags;
               if (tail.live) begin
                  wr.op = WOP_DELETE;
               end
            end
         end
         CMD_LOOKUP: begin
            if (tail.found) begin
               rsp_in.status    = ST_OK;
               rsp_in.out_hop   = tail.hop;
               rsp_in.out_hops  = tail.hops;
               rsp_in.out_flags = tail.flags;
            end else begin
               rsp_in.status = ST_NOTFOUND;
            end
         end
         default: begin
         end
      endcase
      if (!tail.live) begin
         rsp_in = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         launch_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         mask_ff       <= 8'd1;
      end else begin
         busy_ff       <= busy_in;
         launch_ff     <= launch_in;
         rsp_strobe_ff <= rsp_strobe_in;
         mask_ff       <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== src/rtue_checker.sv =====
// Port-level checks for the route table update engine, bound to the top level.
module rtue_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input rtue_pkg::rtue_rsp_type rsp_data,
   input logic                   rsp_strobe
);
   import rtue_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted transaction");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while busy");

   a_fell_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   a_update_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.update_valid |-> rsp_data.status == ST_OK)
      else $error("table change reported with a failing status");

endmodule

bind route_table_update_engine rtue_checker u_rtue_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_strobe(rsp_strobe)
);
